// File: design/ghsa_pkg.sv
// Package for the generational handle slot allocator.
// Holds opcodes, status codes, sizes and the sequencer state type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ghsa_pkg;
  localparam int SLOT_COUNT = 256;
  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [63:0] END_MARK = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] GEN_LIMIT = (64'hffff_ffff_ffff_fffe) / SLOT_COUNT;

  localparam logic [2:0] OP_ALLOC    = 3'd0;
  localparam logic [2:0] OP_FREE     = 3'd1;
  localparam logic [2:0] OP_GET      = 3'd2;
  localparam logic [2:0] OP_COUNT    = 3'd3;
  localparam logic [2:0] OP_FIRST    = 3'd4;
  localparam logic [2:0] OP_NEXT     = 3'd5;
  localparam logic [2:0] OP_STATS    = 3'd6;
  localparam logic [2:0] OP_RESERVED = 3'd7;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_NOKEY   = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_SCAN_RD, S_SCAN_CHK, S_DONE
  } state_t;
endpackage
`default_nettype wire

// File: design/ghsa_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ghsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: design/generational_handle_slot_allocator_core.sv
// Top level: handle table sequencer over tag and value RAMs.
// Depends on ghsa_pkg and ghsa_ram.
// Alloc, free, get, stats, and count/first/next without a scan: read, exec, done states.
// Scans: read and exec, then a scan-read and a scan-check state per slot visited, ending when
// the walk runs off the end or, for first/next, hits. One RAM read port sets the walk.
// One request at a time; busy is high from accept until the result strobe.
// Synchronous reset empties the free list, sets generation to 1, counts to 0.
`timescale 1ns / 1ps
`default_nettype none
module generational_handle_slot_allocator_core import ghsa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode,
  input  wire logic [63:0] handle,
  input  wire logic [63:0] value_in,
  input  wire logic [2:0]  byte_offset,
  input  wire logic [3:0]  byte_len,
  input  wire logic        match_all,
  output logic             done,
  output logic [2:0]       status,
  output logic [63:0]      handle_out,
  output logic [63:0]      value_out,
  output logic [8:0]       match_count,
  output logic [8:0]       used_slots,
  output logic [8:0]       inited_slots
);
  state_t state, state_next;
  logic [2:0]  op;
  logic [63:0] hdl, val;
  logic [2:0]  off;
  logic [3:0]  len;
  logic        all;
  logic [63:0] free_head, generation;
  logic [CNT_W-1:0] used_count, inited_count;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] addr, idx;
  logic        tag_we, val_we;
  logic [63:0] tag_wd, val_wd, tag_rd, val_rd;
  logic        sel_new;

  ghsa_ram #(.WIDTH(64), .DEPTH(SLOT_COUNT)) u_tag (
    .clk(clk), .we(tag_we), .addr(addr), .wdata(tag_wd), .rdata(tag_rd));
  ghsa_ram #(.WIDTH(64), .DEPTH(SLOT_COUNT)) u_val (
    .clk(clk), .we(val_we), .addr(addr), .wdata(val_wd), .rdata(val_rd));

  logic live, win_ok, match;
  logic [63:0] mask, shifted;
  logic [4:0]  span;
  assign live = (tag_rd >= 64'(SLOT_COUNT)) && (tag_rd != END_MARK);
  assign span = 5'(off) + 5'(len);
  assign win_ok = span <= 5'd8;
  assign mask = (len >= 4'd8) ? END_MARK : ((64'd1 << {len[2:0], 3'b000}) - 64'd1);
  assign shifted = val_rd >> {off, 3'b000};
  assign match = live && (((shifted ^ val) & mask) == 64'd0);

  logic [63:0] gen_use, new_tag;
  assign gen_use = (generation >= GEN_LIMIT) ? 64'd1 : generation;
  assign new_tag = {gen_use[63-IDX_W:0], idx};

  always_comb begin
    if (op == OP_ALLOC) begin
      addr = sel_new ? inited_count[IDX_W-1:0] : free_head[IDX_W-1:0];
    end else if (state == S_SCAN_RD || state == S_SCAN_CHK) begin
      addr = scan_idx[IDX_W-1:0];
    end else begin
      addr = hdl[IDX_W-1:0];
    end
  end

  always_comb begin
    tag_we = 1'b0;
    val_we = 1'b0;
    tag_wd = new_tag;
    val_wd = val;
    if (state == S_EXEC) begin
      case (op)
        OP_ALLOC: begin
          if (used_count < CNT_W'(SLOT_COUNT)) begin
            tag_we = 1'b1;
            val_we = 1'b1;
          end
        end
        OP_FREE: begin
          if (live && tag_rd == hdl) begin
            tag_we = 1'b1;
            val_we = 1'b1;
            tag_wd = free_head;
            val_wd = 64'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_READ;
      S_READ: state_next = S_EXEC;
      S_EXEC: begin
        if (op == OP_COUNT && !all && len != 4'd0 && win_ok) state_next = S_SCAN_RD;
        else if (op == OP_FIRST && win_ok) state_next = S_SCAN_RD;
        else if (op == OP_NEXT && win_ok && live && tag_rd == hdl) state_next = S_SCAN_RD;
        else state_next = S_DONE;
      end
      S_SCAN_RD: begin
        if (scan_idx >= inited_count) state_next = S_IDLE;
        else state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (scan_idx >= inited_count) state_next = S_IDLE;
        else if (match && op != OP_COUNT) state_next = S_IDLE;
        else state_next = S_SCAN_RD;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= END_MARK;
      generation <= 64'd1;
      used_count <= '0;
      inited_count <= '0;
      done <= 1'b0;
      op <= OP_STATS;
      sel_new <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= opcode;
            hdl <= handle;
            val <= value_in;
            off <= byte_offset;
            len <= byte_len;
            all <= match_all;
            sel_new <= (used_count == inited_count);
            status <= ST_OK;
            handle_out <= '0;
            value_out <= '0;
            cnt <= '0;
            scan_idx <= '0;
          end
        end
        S_READ: begin
          idx <= addr;
        end
        S_EXEC: begin
          case (op)
            OP_ALLOC: begin
              if (used_count >= CNT_W'(SLOT_COUNT)) begin
                status <= ST_FULL;
              end else begin
                if (sel_new) begin
                  inited_count <= inited_count + 1'b1;
                end else begin
                  free_head <= tag_rd;
                end
                generation <= (generation >= GEN_LIMIT) ? 64'd2 : generation + 64'd1;
                handle_out <= new_tag;
                used_count <= used_count + 1'b1;
              end
            end
            OP_FREE: begin
              if (live && tag_rd == hdl) begin
                free_head <= 64'(idx);
                used_count <= used_count - 1'b1;
              end else begin
                status <= ST_INVALID;
              end
            end
            OP_GET: begin
              if (!live) status <= ST_INVALID;
              else if (tag_rd != hdl) status <= ST_NOKEY;
              else value_out <= val_rd;
            end
            OP_COUNT: begin
              if (all) cnt <= used_count;
              else if (len == 4'd0 || !win_ok) status <= ST_INVALID;
            end
            OP_FIRST: begin
              if (!win_ok) status <= ST_INVALID;
            end
            OP_NEXT: begin
              if (!win_ok || !live || tag_rd != hdl) status <= ST_INVALID;
              else scan_idx <= CNT_W'(idx) + 1'b1;
            end
            OP_STATS: ;
            default: status <= ST_INVALID;
          endcase
          if (state_next == S_DONE) done <= 1'b1;
        end
        S_SCAN_RD: begin
          if (scan_idx >= inited_count) begin
            if (op != OP_COUNT) status <= ST_DONE;
            done <= 1'b1;
          end
        end
        S_SCAN_CHK: begin
          if (scan_idx >= inited_count) begin
            if (op != OP_COUNT) status <= ST_DONE;
            done <= 1'b1;
          end else begin
            if (match) begin
              if (op == OP_COUNT) begin
                cnt <= cnt + 1'b1;
              end else begin
                handle_out <= tag_rd;
                done <= 1'b1;
              end
            end
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  // S_SCAN_CHK compares data read for scan_idx; the RAM read is registered,
  // so S_SCAN_CHK sees data addressed in the previous cycle.
  assign match_count = 9'(cnt);
  assign used_slots = 9'(used_count);
  assign inited_slots = 9'(inited_count);
endmodule
`default_nettype wire

// File: sim/ghsa_checker.sv
// Checker for the handle table: watches request and result ports, predicts results.
// Depends on ghsa_pkg; instantiated by the testbench top beside the block.
`timescale 1ns / 1ps
module ghsa_checker import ghsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  opcode,
  input  logic [63:0] handle,
  input  logic [63:0] value_in,
  input  logic [2:0]  byte_offset,
  input  logic [3:0]  byte_len,
  input  logic        match_all,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [63:0] handle_out,
  input  logic [63:0] value_out,
  input  logic [8:0]  match_count,
  input  logic [8:0]  used_slots,
  input  logic [8:0]  inited_slots,
  output int          fail_count,
  output int          pending
);
  typedef struct {
    logic [2:0]  status;
    logic [63:0] handle_out;
    logic [63:0] value_out;
    logic [8:0]  match_count;
    logic [8:0]  used_slots;
    logic [8:0]  inited_slots;
  } reply_t;

  logic [63:0] tag_mem [SLOT_COUNT];
  logic [63:0] val_mem [SLOT_COUNT];
  logic [63:0] free_head;
  logic [63:0] gen;
  int          used_cnt;
  int          inited_cnt;
  reply_t      reply_q[$];

  function automatic bit live(logic [63:0] t);
    return t >= SLOT_COUNT && t != END_MARK;
  endfunction

  function automatic bit window_hit(logic [63:0] stored, logic [63:0] pat,
                                    int off, int len);
    logic [63:0] mask;
    mask = (len >= 8) ? END_MARK : ((64'd1 << (8 * len)) - 64'd1);
    return (((stored >> (8 * off)) ^ pat) & mask) == 64'd0;
  endfunction

  function automatic bit find_live(int from, logic [63:0] pat, int off, int len,
                                   output logic [63:0] hit);
    hit = '0;
    for (int i = from; i < inited_cnt; i++) begin
      if (live(tag_mem[i]) && window_hit(val_mem[i], pat, off, len)) begin
        hit = tag_mem[i];
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic reply_t predict_request(logic [2:0] op, logic [63:0] h,
                                             logic [63:0] v, int off, int len,
                                             logic all);
    reply_t r;
    int idx;
    logic [63:0] g;
    logic [63:0] hit;
    r = '{ST_OK, '0, '0, '0, '0, '0};
    idx = h % SLOT_COUNT;
    case (op)
      OP_ALLOC: begin
        if (used_cnt >= SLOT_COUNT) begin
          r.status = ST_FULL;
        end else begin
          if (used_cnt == inited_cnt) begin
            idx = inited_cnt;
            inited_cnt++;
          end else begin
            idx = free_head % SLOT_COUNT;
            free_head = tag_mem[idx];
          end
          g = gen;
          gen = g + 1;
          if (g >= GEN_LIMIT) begin
            gen = 2;
            g = 1;
          end
          tag_mem[idx] = g * SLOT_COUNT + idx;
          val_mem[idx] = v;
          r.handle_out = tag_mem[idx];
          used_cnt++;
        end
      end
      OP_FREE: begin
        if (!live(tag_mem[idx]) || tag_mem[idx] != h) begin
          r.status = ST_INVALID;
        end else begin
          tag_mem[idx] = free_head;
          free_head = idx;
          val_mem[idx] = '0;
          used_cnt--;
        end
      end
      OP_GET: begin
        if (!live(tag_mem[idx])) r.status = ST_INVALID;
        else if (tag_mem[idx] != h) r.status = ST_NOKEY;
        else r.value_out = val_mem[idx];
      end
      OP_COUNT: begin
        if (all) begin
          r.match_count = used_cnt;
        end else if (len == 0 || off + len > 8) begin
          r.status = ST_INVALID;
        end else begin
          for (int i = 0; i < inited_cnt; i++)
            if (live(tag_mem[i]) && window_hit(val_mem[i], v, off, len))
              r.match_count++;
        end
      end
      OP_FIRST: begin
        if (off + len > 8) r.status = ST_INVALID;
        else if (find_live(0, v, off, len, hit)) r.handle_out = hit;
        else r.status = ST_DONE;
      end
      OP_NEXT: begin
        if (off + len > 8) r.status = ST_INVALID;
        else if (!live(tag_mem[idx]) || tag_mem[idx] != h) r.status = ST_INVALID;
        else if (find_live(idx + 1, v, off, len, hit)) r.handle_out = hit;
        else r.status = ST_DONE;
      end
      OP_STATS: ;
      default: r.status = ST_INVALID;
    endcase
    r.used_slots = used_cnt;
    r.inited_slots = inited_cnt;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    reply_t e;
    if (rst) begin
      free_head = END_MARK;
      gen = 1;
      used_cnt = 0;
      inited_cnt = 0;
      reply_q.delete();
    end else begin
      if (done) begin
        if (reply_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          e = reply_q.pop_front();
          check_field("status", e.status, status);
          check_field("handle_out", e.handle_out, handle_out);
          check_field("value_out", e.value_out, value_out);
          check_field("match_count", e.match_count, match_count);
          check_field("used_slots", e.used_slots, used_slots);
          check_field("inited_slots", e.inited_slots, inited_slots);
        end
      end
      if (start && !busy)
        reply_q.push_back(predict_request(opcode, handle, value_in, byte_offset,
                                          byte_len, match_all));
    end
    pending = reply_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    free_head = END_MARK;
  end
endmodule

// File: sim/testbench.sv
// Testbench top for generational_handle_slot_allocator_core: clock, reset, requests.
// Depends on ghsa_pkg, the core RTL and ghsa_checker.
`timescale 1ns / 1ps
module testbench;
  import ghsa_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [2:0]  opcode = '0;
  logic [63:0] handle = '0;
  logic [63:0] value_in = '0;
  logic [2:0]  byte_offset = '0;
  logic [3:0]  byte_len = '0;
  logic        match_all = 0;
  logic        done;
  logic [2:0]  status;
  logic [63:0] handle_out;
  logic [63:0] value_out;
  logic [8:0]  match_count;
  logic [8:0]  used_slots;
  logic [8:0]  inited_slots;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          n_requests = 0;
  int          n_full = 0;
  int          inited_now = 0;
  logic [63:0] live_q[$];

  always #4 clk = ~clk;

  generational_handle_slot_allocator_core u_top (.*);
  ghsa_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 5000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic issue(logic [2:0] op, logic [63:0] h, logic [63:0] v,
                       logic [2:0] off, logic [3:0] len, logic all);
    int gap;
    gap = $urandom_range(0, 16);
    @(negedge clk);
    repeat (gap) @(negedge clk);
    start <= 1;
    opcode <= op;
    handle <= h;
    value_in <= v;
    byte_offset <= off;
    byte_len <= len;
    match_all <= all;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start <= 0;
    do @(posedge clk); while (!done);
    n_requests++;
    inited_now = inited_slots;
    if (status == ST_FULL) n_full++;
    if (op == OP_ALLOC && status == ST_OK) live_q.push_back(handle_out);
    if (op == OP_FREE && status == ST_OK)
      foreach (live_q[i]) if (live_q[i] == h) begin
        live_q.delete(i);
        break;
      end
  endtask

  // random handle whose slot was written at least once
  function automatic logic [63:0] pick_handle();
    logic [63:0] h;
    h = {$urandom, $urandom};
    if (live_q.size() != 0 && $urandom_range(0, 9) < 7)
      h = live_q[$urandom_range(0, live_q.size() - 1)];
    else if ($urandom_range(0, 1))
      h[IDX_W-1:0] = IDX_W'($urandom_range(0, inited_now - 1));
    else
      h = (live_q.size() != 0) ? live_q[0] + SLOT_COUNT : {$urandom, $urandom};
    h[IDX_W-1:0] = IDX_W'(h[IDX_W-1:0] % inited_now);
    return h;
  endfunction

  initial begin
    logic [63:0] h0;
    logic [2:0]  op;
    int          roll;
    int          alloc_pct;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    issue(OP_FIRST, '0, '0, 0, 0, 0);
    issue(OP_ALLOC, '0, END_MARK, 0, 0, 0);
    issue(OP_ALLOC, '0, '0, 0, 0, 0);
    issue(OP_ALLOC, '0, 64'h0123_4567_89ab_cdef, 0, 0, 0);
    h0 = live_q[0];
    issue(OP_GET, h0, '0, 0, 0, 0);
    issue(OP_GET, h0 + SLOT_COUNT, '0, 0, 0, 0);
    issue(OP_COUNT, '0, 64'hff, 7, 1, 0);
    issue(OP_COUNT, '0, '0, 0, 0, 1);
    issue(OP_COUNT, '0, '0, 0, 0, 0);
    issue(OP_COUNT, '0, '0, 7, 2, 0);
    issue(OP_FIRST, '0, 64'h89ab, 2, 2, 0);
    issue(OP_FIRST, '0, 64'h5555, 0, 8, 0);
    issue(OP_FIRST, '0, '0, 0, 15, 0);
    issue(OP_NEXT, h0, '0, 0, 0, 0);
    issue(OP_NEXT, live_q[2], '0, 0, 0, 0);
    issue(OP_NEXT, h0 ^ 64'h100, '0, 0, 0, 0);
    issue(OP_FREE, h0, '0, 0, 0, 0);
    issue(OP_FREE, h0, '0, 0, 0, 0);
    issue(OP_GET, h0, '0, 0, 0, 0);
    issue(OP_NEXT, h0, '0, 0, 0, 0);
    issue(OP_STATS, END_MARK, END_MARK, 7, 15, 1);
    issue(OP_RESERVED, '0, '0, 0, 0, 0);
    issue(OP_ALLOC, '0, 64'hdead_beef, 0, 0, 0);

    for (int k = 0; k < 1130; k++) begin
      alloc_pct = ((k / 300) % 2 == 0) ? 60 : 15;
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct || inited_now == 0) op = OP_ALLOC;
      else if (roll < alloc_pct + 20) op = OP_FREE;
      else if (roll < 97) op = 3'($urandom_range(2, 6));
      else op = OP_RESERVED;
      issue(op, (inited_now == 0) ? {$urandom, $urandom} : pick_handle(),
            ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 3)),
            3'($urandom),
            ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3)),
            $urandom_range(0, 7) == 0);
    end

    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Ran %0d requests over %0d cycles, %0d hit a full table.",
             n_requests, cycles, n_full);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// File: files.f
design/ghsa_pkg.sv
design/ghsa_ram.sv
design/generational_handle_slot_allocator_core.sv
sim/ghsa_checker.sv
sim/testbench.sv
